FILE: sv/urm_pkg.sv
// Shared types and constants for the URM instruction execute block.
// No dependencies; used by every module of the block.
`default_nettype none

package urm_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W  = 2;
  localparam int REG_W  = 8;
  localparam int IDX_W  = 16;
  localparam int NEXT_W = IDX_W + 1;
  localparam int WVAL_W = 32;

  // Default sizing of the register file
  localparam int NUM_REGS_DEF   = 256;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ZERO = 2'd0,
    CMD_SUCC = 2'd1,
    CMD_XFER = 2'd2,
    CMD_JEQ  = 2'd3
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // clearing pass: write zero at the sweep address
    logic accept;  // item taken this cycle: capture fields, launch reads
    logic exec;    // item in execute stage: compute, write back, load result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep address is at the last entry
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: sv/urm_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Depends on urm_pkg for default sizes only.
`default_nettype none

module urm_ram #(
  parameter int WIDTH = urm_pkg::VALUE_BITS_DEF,
  parameter int DEPTH = urm_pkg::NUM_REGS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read on the write edge returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/urm_ctrl.sv
// Controller for the URM execute block: clearing pass, then run.
// Depends on urm_pkg for the command and status structs.
`default_nettype none

module urm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire urm_pkg::ctl_sts_t sts_i,
  output urm_pkg::ctl_cmd_t      cmd_o,
  output logic                   busy,
  output logic                   done_o
);
  import urm_pkg::*;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   exec_q, exec_d;
  logic   done_q, done_d;
  logic   accept;

  assign busy   = (state_q == ST_CLEAR);
  assign accept = start && (state_q == ST_RUN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clear_last) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
    exec_d = accept;
    done_d = exec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      exec_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      exec_q  <= exec_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.accept = accept;
  assign cmd_o.exec   = exec_q;
  assign done_o       = done_q;

endmodule

`default_nettype wire

FILE: sv/urm_dpath.sv
// Datapath for the URM execute block: register file, execute stage,
// write bypass and result registers. Depends on urm_pkg and urm_ram.
`default_nettype none

module urm_dpath #(
  parameter int NUM_REGS   = urm_pkg::NUM_REGS_DEF,
  parameter int VALUE_BITS = urm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire urm_pkg::ctl_cmd_t                cmd_i,
  output urm_pkg::ctl_sts_t                     sts_o,
  input  wire logic [urm_pkg::CMD_W-1:0]        command_i,
  input  wire logic [urm_pkg::REG_W-1:0]        reg_a_i,
  input  wire logic [urm_pkg::REG_W-1:0]        reg_b_i,
  input  wire logic [urm_pkg::IDX_W-1:0]        jump_target_i,
  input  wire logic [urm_pkg::IDX_W-1:0]        instr_index_i,
  output logic                                  wrote_o,
  output logic      [urm_pkg::REG_W-1:0]        written_reg_o,
  output logic      [urm_pkg::WVAL_W-1:0]       written_value_o,
  output logic                                  jump_taken_o,
  output logic signed [urm_pkg::NEXT_W-1:0]     next_index_o
);
  import urm_pkg::*;

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef logic [VALUE_BITS-1:0] val_t;

  // clearing sweep
  logic [AW-1:0] clr_addr_q;

  // execute stage operands
  cmd_e             ex_cmd_q;
  logic [REG_W-1:0] ex_ra_q, ex_rb_q;
  logic [IDX_W-1:0] ex_tgt_q, ex_idx_q;
  logic             ex_a_ok_q, ex_b_ok_q;

  // last write, for the item right behind it
  logic             fwd_en_q;
  logic [REG_W-1:0] fwd_reg_q;
  val_t             fwd_data_q;

  val_t rd_a, rd_b, opa, opb;
  logic a_ok, b_ok;

  logic              wr, dest_ok, jmp, wr_en;
  logic [REG_W-1:0]  wreg;
  val_t              wval;
  logic [NEXT_W-1:0] next_idx;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  val_t              ram_wdata;

  logic                     wrote_q, jmp_q;
  logic [REG_W-1:0]         wreg_q;
  logic [WVAL_W-1:0]        wval_q;
  logic signed [NEXT_W-1:0] next_q;

  // register numbers past the file read zero and drop writes
  assign a_ok = (32'(reg_a_i) < 32'(NUM_REGS));
  assign b_ok = (32'(reg_b_i) < 32'(NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      fwd_en_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + AW'(1);
      fwd_en_q <= wr_en;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == AW'(NUM_REGS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ex_cmd_q  <= cmd_e'(command_i);
      ex_ra_q   <= reg_a_i;
      ex_rb_q   <= reg_b_i;
      ex_tgt_q  <= jump_target_i;
      ex_idx_q  <= instr_index_i;
      ex_a_ok_q <= a_ok;
      ex_b_ok_q <= b_ok;
    end
    fwd_reg_q  <= wreg;
    fwd_data_q <= wval;
  end

  urm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (cmd_i.accept),
    .raddr_a_i (AW'(reg_a_i)),
    .raddr_b_i (AW'(reg_b_i)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // operands with bypass of the write retired in the previous cycle
  always_comb begin
    if (!ex_a_ok_q)                              opa = '0;
    else if (fwd_en_q && fwd_reg_q == ex_ra_q)   opa = fwd_data_q;
    else                                         opa = rd_a;
    if (!ex_b_ok_q)                              opb = '0;
    else if (fwd_en_q && fwd_reg_q == ex_rb_q)   opb = fwd_data_q;
    else                                         opb = rd_b;
  end

  always_comb begin
    wr      = 1'b0;
    dest_ok = 1'b0;
    jmp     = 1'b0;
    wreg    = '0;
    wval    = '0;
    case (ex_cmd_q)
      CMD_ZERO: begin
        wr      = 1'b1;
        wreg    = ex_ra_q;
        dest_ok = ex_a_ok_q;
      end
      CMD_SUCC: begin
        wr      = 1'b1;
        wreg    = ex_ra_q;
        wval    = opa + val_t'(1);
        dest_ok = ex_a_ok_q;
      end
      CMD_XFER: begin
        wr      = 1'b1;
        wreg    = ex_rb_q;
        wval    = opa;
        dest_ok = ex_b_ok_q;
      end
      CMD_JEQ: jmp = (opa == opb);
      default: ;
    endcase
    wr_en    = cmd_i.exec && wr && dest_ok;
    // target 0 gives all ones, i.e. -1
    next_idx = jmp ? ({1'b0, ex_tgt_q} - NEXT_W'(1)) : {1'b0, ex_idx_q};
  end

  always_comb begin
    ram_we    = cmd_i.clear || wr_en;
    ram_waddr = cmd_i.clear ? clr_addr_q : AW'(wreg);
    ram_wdata = cmd_i.clear ? '0 : wval;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      wrote_q <= wr;
      wreg_q  <= wreg;
      wval_q  <= WVAL_W'(wval);
      jmp_q   <= jmp;
      next_q  <= $signed(next_idx);
    end
  end

  assign wrote_o         = wrote_q;
  assign written_reg_o   = wreg_q;
  assign written_value_o = wval_q;
  assign jump_taken_o    = jmp_q;
  assign next_index_o    = next_q;

endmodule

`default_nettype wire

FILE: sv/urm_instruction_execute_top.sv
// URM instruction execute block, top level: controller plus datapath.
// Depends on urm_pkg, urm_ctrl, urm_dpath (and urm_ram below it).
//
// Executes one Unlimited Register Machine instruction per item: zero,
// successor (wrapping at VALUE_BITS), transfer, and jump-if-equal. After
// reset, busy stays high while a clearing pass writes zero into every
// entry of the register file, one entry a cycle; start is ignored until
// then. From that point busy stays low for good and an item is taken on
// every cycle with start high, so the block sustains one instruction per
// clock. Each item yields exactly one result, strobed by done_o for a
// single cycle once it has passed the registered read of the
// register-file RAM and the execute stage that computes and writes back;
// the receiver cannot stall and must take it then. A one-entry bypass
// hands each write to the item right behind it. Register numbers at or
// above NUM_REGS read as zero and their writes are dropped, though the
// result still reports them. written_value_o carries the low 32 bits of
// the value; next_index_o is the jump target minus one on a taken jump,
// else the incoming index.
`default_nettype none

module urm_instruction_execute_top #(
  parameter int NUM_REGS   = urm_pkg::NUM_REGS_DEF,
  parameter int VALUE_BITS = urm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [urm_pkg::CMD_W-1:0]    command_i,
  input  wire logic [urm_pkg::REG_W-1:0]    reg_a_i,
  input  wire logic [urm_pkg::REG_W-1:0]    reg_b_i,
  input  wire logic [urm_pkg::IDX_W-1:0]    jump_target_i,
  input  wire logic [urm_pkg::IDX_W-1:0]    instr_index_i,
  output logic                              done_o,
  output logic                              wrote_o,
  output logic      [urm_pkg::REG_W-1:0]    written_reg_o,
  output logic      [urm_pkg::WVAL_W-1:0]   written_value_o,
  output logic                              jump_taken_o,
  output logic signed [urm_pkg::NEXT_W-1:0] next_index_o
);
  import urm_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  urm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (ctl_sts),
    .cmd_o  (ctl_cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  urm_dpath #(
    .NUM_REGS   (NUM_REGS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctl_cmd),
    .sts_o           (ctl_sts),
    .command_i       (command_i),
    .reg_a_i         (reg_a_i),
    .reg_b_i         (reg_b_i),
    .jump_target_i   (jump_target_i),
    .instr_index_i   (instr_index_i),
    .wrote_o         (wrote_o),
    .written_reg_o   (written_reg_o),
    .written_value_o (written_value_o),
    .jump_taken_o    (jump_taken_o),
    .next_index_o    (next_index_o)
  );

`ifndef SYNTHESIS
  // every accepted item gives its result on done_o
  a_item_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted item produced no result");

  a_result_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching item");

  // once the clearing pass ends the block never returns to it
  a_busy_stays_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after clearing pass");

  a_jump_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && jump_taken_o) |-> !wrote_o)
    else $error("taken jump also reported a write");

  a_nowrite_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !wrote_o) |-> (written_reg_o == '0 && written_value_o == '0))
    else $error("non-writing result carries register data");
`endif

endmodule

`default_nettype wire

FILE: test/urm_result_checker.sv
// Result checker for the URM instruction execute block: watches the item and
// result channels, predicts each result and compares it field by field.
// Depends on urm_pkg for field widths and the command encoding.
`default_nettype none

module urm_result_checker #(
  parameter int NUM_REGS   = urm_pkg::NUM_REGS_DEF,
  parameter int VALUE_BITS = urm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         busy_i,
  input  wire logic [urm_pkg::CMD_W-1:0]    command_i,
  input  wire logic [urm_pkg::REG_W-1:0]    reg_a_i,
  input  wire logic [urm_pkg::REG_W-1:0]    reg_b_i,
  input  wire logic [urm_pkg::IDX_W-1:0]    jump_target_i,
  input  wire logic [urm_pkg::IDX_W-1:0]    instr_index_i,
  input  wire logic                         done_i,
  input  wire logic                         wrote_i,
  input  wire logic [urm_pkg::REG_W-1:0]    written_reg_i,
  input  wire logic [urm_pkg::WVAL_W-1:0]   written_value_i,
  input  wire logic                         jump_taken_i,
  input  wire logic signed [urm_pkg::NEXT_W-1:0] next_index_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import urm_pkg::*;

  typedef struct packed {
    logic                     wrote;
    logic [REG_W-1:0]         wreg;
    logic [WVAL_W-1:0]        wval;
    logic                     jumped;
    logic signed [NEXT_W-1:0] next;
  } urm_result_t;

  logic [VALUE_BITS-1:0] machine_regs [NUM_REGS];
  urm_result_t           expected_results [$];
  int                    fail_cnt    = 0;
  int                    results_cnt = 0;

  function automatic logic [VALUE_BITS-1:0] fetch_reg(input int n);
    if (n < NUM_REGS) return machine_regs[n];
    return '0;
  endfunction

  // writes beyond the file are dropped, the result still reports them
  function automatic void store_reg(input int n, input logic [VALUE_BITS-1:0] v);
    if (n < NUM_REGS) machine_regs[n] = v;
  endfunction

  function automatic urm_result_t execute_instr(
    input cmd_e             cmd,
    input logic [REG_W-1:0] ra,
    input logic [REG_W-1:0] rb,
    input logic [IDX_W-1:0] target,
    input logic [IDX_W-1:0] idx
  );
    urm_result_t           r;
    logic [VALUE_BITS-1:0] v;
    r      = '0;
    r.next = {1'b0, idx};
    case (cmd)
      CMD_ZERO: begin
        store_reg(ra, '0);
        r.wrote = 1'b1;
        r.wreg  = ra;
      end
      CMD_SUCC: begin
        v = fetch_reg(ra) + 1'b1;
        store_reg(ra, v);
        r.wrote = 1'b1;
        r.wreg  = ra;
        r.wval  = WVAL_W'(v);
      end
      CMD_XFER: begin
        v = fetch_reg(ra);
        store_reg(rb, v);
        r.wrote = 1'b1;
        r.wreg  = rb;
        r.wval  = WVAL_W'(v);
      end
      default: begin
        if (fetch_reg(ra) == fetch_reg(rb)) begin
          r.jumped = 1'b1;
          r.next   = {1'b0, target} - 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    urm_result_t got;
    urm_result_t want;
    if (!rst_ni) begin
      foreach (machine_regs[i]) machine_regs[i] = '0;
      expected_results.delete();
    end else begin
      // results leave in order, so compare before this edge's item is queued
      if (done_i === 1'b1) begin
        got = '{wrote_i, written_reg_i, written_value_i, jump_taken_i, next_index_i};
        results_cnt++;
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result %0d with none expected: wrote %0b reg %0d value %h",
                     $realtime, results_cnt, got.wrote, got.wreg, got.wval);
        end else begin
          want = expected_results.pop_front();
          if (got.wrote !== want.wrote || got.wreg !== want.wreg ||
              got.wval !== want.wval || got.jumped !== want.jumped ||
              got.next !== want.next) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: result %0d mismatch (expected / actual)", $realtime, results_cnt);
              $display("  wrote %0b / %0b  reg %0d / %0d  value %h / %h",
                       want.wrote, got.wrote, want.wreg, got.wreg, want.wval, got.wval);
              $display("  jump %0b / %0b  next %0d / %0d",
                       want.jumped, got.jumped, want.next, got.next);
            end
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_results.push_back(execute_instr(cmd_e'(command_i), reg_a_i, reg_b_i,
                                                 jump_target_i, instr_index_i));
    end
    fail_count_o <= fail_cnt;
    pending_o    <= expected_results.size();
  end

endmodule

`default_nettype wire

FILE: test/tb_urm_instruction_execute_top.sv
// Testbench top for urm_instruction_execute_top: clock, reset, item stimulus
// and the verdict. Depends on urm_pkg, the block's RTL and urm_result_checker.
`default_nettype none

module tb_urm_instruction_execute_top;
  timeunit 1ns;
  timeprecision 1ps;

  import urm_pkg::*;

  localparam int NUM_REGS    = NUM_REGS_DEF;
  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int RAND_ITEMS  = 1900;
  // clearing pass plus about 2000 items, with short idle gaps between
  // bursts, stays far below this limit
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;      // quiet wait after the last result

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  cmd_e                 command     = CMD_ZERO;
  logic [REG_W-1:0]     reg_a       = '0;
  logic [REG_W-1:0]     reg_b       = '0;
  logic [IDX_W-1:0]     jump_target = '0;
  logic [IDX_W-1:0]     instr_index = '0;
  logic                 done;
  logic                 wrote;
  logic [REG_W-1:0]     written_reg;
  logic [WVAL_W-1:0]    written_value;
  logic                 jump_taken;
  logic signed [NEXT_W-1:0] next_index;
  int                   fail_count;
  int                   pending;
  int                   cycle_cnt   = 0;

  // 2 ns clock: high then low
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  urm_instruction_execute_top #(
    .NUM_REGS   (NUM_REGS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .command_i       (command),
    .reg_a_i         (reg_a),
    .reg_b_i         (reg_b),
    .jump_target_i   (jump_target),
    .instr_index_i   (instr_index),
    .done_o          (done),
    .wrote_o         (wrote),
    .written_reg_o   (written_reg),
    .written_value_o (written_value),
    .jump_taken_o    (jump_taken),
    .next_index_o    (next_index)
  );

  // Watches both channels, predicts and compares; hands back the failure
  // count and the number of results still owed by the block.
  urm_result_checker #(
    .NUM_REGS   (NUM_REGS),
    .VALUE_BITS (VALUE_BITS)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .command_i       (command),
    .reg_a_i         (reg_a),
    .reg_b_i         (reg_b),
    .jump_target_i   (jump_target),
    .instr_index_i   (instr_index),
    .done_i          (done),
    .wrote_i         (wrote),
    .written_reg_i   (written_reg),
    .written_value_i (written_value),
    .jump_taken_i    (jump_taken),
    .next_index_i    (next_index),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one item at this edge and hold it until the block takes it.
  // Called at a rising edge; returns at the edge that accepted the item, so
  // a following call keeps start high without a second assignment that step.
  task automatic issue_instr(
    input cmd_e             cmd,
    input logic [REG_W-1:0] ra,
    input logic [REG_W-1:0] rb,
    input logic [IDX_W-1:0] target,
    input logic [IDX_W-1:0] idx
  );
    start       <= 1'b1;
    command     <= cmd;
    reg_a       <= ra;
    reg_b       <= rb;
    jump_target <= target;
    instr_index <= idx;
    // busy covers the clearing pass after reset
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Register numbers: mostly a few low and high registers so that values
  // build up, repeat and compare equal; a quarter anywhere in the file.
  function automatic logic [REG_W-1:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return REG_W'($urandom_range(0, 255));
      1, 2:    return REG_W'($urandom_range(0, 7));
      default: return REG_W'($urandom_range(248, 255));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return IDX_W'(1);
      default: return IDX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cmd_e pick_cmd();
    case ($urandom_range(0, 9))
      0, 1:    return CMD_ZERO;
      2, 3, 4: return CMD_SUCC;
      5, 6:    return CMD_XFER;
      default: return CMD_JEQ;
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    int gap;

    // hold reset, then release it on a rising edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // fresh registers read zero: jump taken, target 0 gives index -1
    issue_instr(CMD_JEQ,  8'd0,   8'd255, 16'h0000, 16'hFFFF);
    issue_instr(CMD_SUCC, 8'd255, 8'd0,   16'hFFFF, 16'h0000);
    // now unequal: not taken, index passes through
    issue_instr(CMD_JEQ,  8'd0,   8'd255, 16'hFFFF, 16'h0000);
    issue_instr(CMD_SUCC, 8'd0,   8'hFF,  16'h0000, 16'hFFFF);
    // equal again, largest target
    issue_instr(CMD_JEQ,  8'd255, 8'd0,   16'hFFFF, 16'h1234);
    // a read right behind an update of the same register goes through the bypass
    issue_instr(CMD_SUCC, 8'd0,   8'd0,   16'h0000, 16'h0001);
    issue_instr(CMD_XFER, 8'd0,   8'd128, 16'h0000, 16'h0002);
    // transfer onto itself keeps the value
    issue_instr(CMD_XFER, 8'd128, 8'd128, 16'h0000, 16'h0003);
    issue_instr(CMD_SUCC, 8'd128, 8'd1,   16'h0000, 16'h0004);
    // jump comparing a register with itself always taken
    issue_instr(CMD_JEQ,  8'd128, 8'd128, 16'h0001, 16'h0005);
    issue_instr(CMD_ZERO, 8'd128, 8'd0,   16'h0000, 16'h0006);
    issue_instr(CMD_ZERO, 8'd0,   8'hFF,  16'hFFFF, 16'hFFFF);
    issue_instr(CMD_XFER, 8'h55,  8'hAA,  16'h5555, 16'hAAAA);
    issue_instr(CMD_SUCC, 8'hAA,  8'h55,  16'hAAAA, 16'h5555);
    issue_instr(CMD_SUCC, 8'hAA,  8'h00,  16'h0000, 16'h0000);
    issue_instr(CMD_XFER, 8'hAA,  8'h55,  16'h0000, 16'h0000);
    issue_instr(CMD_JEQ,  8'h55,  8'hAA,  16'h8000, 16'h7FFF);
    issue_instr(CMD_JEQ,  8'h55,  8'd255, 16'h8000, 16'h7FFF);

    // ---- random part: bursts of items with random gaps ----
    sent = 0;
    while (sent < RAND_ITEMS) begin
      // mostly short bursts, now and then a long unbroken run
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        issue_instr(pick_cmd(), pick_reg(), pick_reg(), pick_index(), pick_index());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        // idle with junk on the fields; the block must ignore it
        start       <= 1'b0;
        command     <= pick_cmd();
        reg_a       <= REG_W'($urandom());
        reg_b       <= REG_W'($urandom());
        jump_target <= IDX_W'($urandom());
        instr_index <= IDX_W'($urandom());
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // ---- wind down: every result in, then a quiet drain wait ----
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
